FILE: rtl/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types and constants of the rectangle grid placer: field widths,
// result status codes, controller states and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rgp_pkg;

   // Coordinates and sizes are unsigned Q10.4.
   localparam int COORD_W   = 14;
   localparam int CSR_ADR_W = 1;
   localparam int SLOT_W    = 6;

   // Candidate position widths: x may pass the board by one step, y by one row.
   localparam int CAND_X_W = COORD_W + 2;
   localparam int CAND_Y_W = COORD_W + 1;

   // One grid unit is 1.0 in Q10.4.
   localparam int FRAC_BITS = 4;
   localparam logic [CAND_X_W-1:0] UNIT_STEP = CAND_X_W'(1 << FRAC_BITS);

   localparam logic [COORD_W-1:0] BOARD_RESET = 14'd320;

   // Register indexes.
   localparam logic [CSR_ADR_W-1:0] CSR_BOARD_WIDTH  = 1'b0;
   localparam logic [CSR_ADR_W-1:0] CSR_BOARD_HEIGHT = 1'b1;

   // Action codes.
   localparam logic ACT_PLACE = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Padded payload widths on the stream ports.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_BOUND,
      S_READ,
      S_CHECK,
      S_ADVANCE,
      S_WRAP,
      S_EMIT
   } ctrl_state_type;

   // One stored rectangle.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } rect_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic           load;
      logic           k_reset;
      logic           k_inc;
      logic           hit;
      logic           advance;
      logic           wrap;
      logic           emit;
      rsp_status_type code;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_clear;
      logic full;
      logic in_bounds;
      logic k_end;
      logic overlap;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: rtl/rectangle_grid_placer_core.sv
// ----------------------------------------------------------------------------
// rectangle_grid_placer_core
// Bottom-left grid placement of rectangles on a board of configurable size.
// ----------------------------------------------------------------------------
// Usage:
// Each req item is a place or clear request (req_tuser). A place request is
// scanned from (0,0) on the unit grid, right then up, against the stored table;
// the first free position is stored and returned with its slot. One rsp item
// follows each req item, its status in rsp_tuser.
// A clear or full-table item goes from the decide state straight to its
// result. A place item runs, for each candidate position, a bounds test,
// then reads and compares the stored entries in turn (one table read port,
// one entry per compare), and moves past a blocker in an advance and a wrap
// step. The final free position is compared against every stored entry
// before the table walk closes. One item is in flight at a time;
// req_tready is high only while idle. The result sits in an output
// register, so a new item is taken while the previous result waits; a
// stalled rsp holds the scan before its result. Reset empties the table and
// restores a 20.0 x 20.0 board. The user must write the board registers on
// the csr port only while no item is in flight; the core does not enforce it.
// ----------------------------------------------------------------------------
module rectangle_grid_placer_core #(
   parameter int MAX_RECTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration writes.
   input  logic                            csr_we,
   input  logic [rgp_pkg::CSR_ADR_W-1:0]   csr_addr,
   input  logic [rgp_pkg::COORD_W-1:0]     csr_wdata,
   // Requests.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [13:0] rect_width, [27:14] rect_height, [31:28] zero
   input  logic [rgp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] action
   input  logic                            req_tuser,
   // Results.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [13:0] pos_x, [27:14] pos_y, [33:28] slot, [39:34] zero
   output logic [rgp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]                      rsp_tuser
);
   import rgp_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer.
   rgp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table, scan arithmetic and output register.
   rgp_datapath #(
      .MAX_RECTS (MAX_RECTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/rgp_ctrl.sv
// ----------------------------------------------------------------------------
// rgp_ctrl
// Sequencer of the placer: takes an item, walks the candidate positions and
// the stored table one entry at a time, and hands the result to the output.
// ----------------------------------------------------------------------------
module rgp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rgp_pkg::dp_sts_type sts,
   output rgp_pkg::dp_cmd_type cmd
);
   import rgp_pkg::*;

   ctrl_state_type state_ff, state_in;
   rsp_status_type code_ff, code_in;

   // State and result code registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_PLACED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      cmd        = '0;
      cmd.code   = code_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_clear) begin
               code_in  = ST_CLEARED;
               state_in = S_EMIT;
            end else if (sts.full) begin
               code_in  = ST_FULL;
               state_in = S_EMIT;
            end else begin
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            if (!sts.in_bounds) begin
               code_in  = ST_NOFIT;
               state_in = S_EMIT;
            end else begin
               cmd.k_reset = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            // The table read of entry k is registered during this cycle.
            if (sts.k_end) begin
               code_in  = ST_PLACED;
               state_in = S_EMIT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.overlap) begin
               cmd.hit  = 1'b1;
               state_in = S_ADVANCE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_READ;
            end
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = S_WRAP;
         end
         S_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = S_BOUND;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/rgp_datapath.sv
// ----------------------------------------------------------------------------
// rgp_datapath
// Board registers, rectangle table, candidate position, overlap test and
// the output register of the placer.
// ----------------------------------------------------------------------------
module rgp_datapath #(
   parameter int MAX_RECTS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rgp_pkg::CSR_ADR_W-1:0]          csr_addr,
   input  logic [rgp_pkg::COORD_W-1:0]            csr_wdata,
   input  logic [rgp_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic                                   req_tuser,
   input  rgp_pkg::dp_cmd_type                    cmd,
   output rgp_pkg::dp_sts_type                    sts,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rgp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [1:0]                             rsp_tuser
);
   import rgp_pkg::*;

   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

   logic [COORD_W-1:0]  board_w_ff, board_h_ff;
   logic                action_ff;
   logic [COORD_W-1:0]  w_ff, h_ff;
   logic [CAND_X_W-1:0] x_ff;
   logic [CAND_Y_W-1:0] y_ff;
   logic [CNT_W-1:0]    count_ff, k_ff;
   logic [CAND_Y_W-1:0] edge_ff;
   rect_entry_type      mem [MAX_RECTS];
   rect_entry_type      rd_ff;

   logic                rsp_valid_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   rsp_status_type      rsp_status_ff;

   logic [CAND_X_W:0]         x_end;
   logic [CAND_Y_W:0]         y_end;
   logic [CAND_Y_W:0]         ent_x_end, ent_y_end;
   logic [CAND_Y_W-1:0]       gap;
   logic [CAND_X_W-1:0]       step;
   logic [CNT_W+SLOT_W-1:0]   count_ext;
   logic                      placed;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         board_w_ff <= BOARD_RESET;
         board_h_ff <= BOARD_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_BOARD_WIDTH)  board_w_ff <= csr_wdata;
         if (csr_addr == CSR_BOARD_HEIGHT) board_h_ff <= csr_wdata;
      end
   end

   // Candidate extents and stored entry extents, without wrapping.
   assign x_end     = {1'b0, x_ff} + (CAND_X_W + 1)'(w_ff);
   assign y_end     = {1'b0, y_ff} + (CAND_Y_W + 1)'(h_ff);
   assign ent_x_end = (CAND_Y_W + 1)'(rd_ff.x) + (CAND_Y_W + 1)'(rd_ff.w);
   assign ent_y_end = (CAND_Y_W + 1)'(rd_ff.y) + (CAND_Y_W + 1)'(rd_ff.h);

   // Status toward the controller.
   always_comb begin
      sts.is_clear  = (action_ff == ACT_CLEAR);
      sts.full      = (count_ff == CNT_W'(MAX_RECTS));
      sts.in_bounds = (x_end <= (CAND_X_W + 1)'(board_w_ff)) &&
                      (y_end <= (CAND_Y_W + 1)'(board_h_ff));
      sts.k_end     = (k_ff == count_ff);
      sts.overlap   = ((CAND_Y_W + 1)'(x_ff) < ent_x_end) &&
                      (x_end > (CAND_X_W + 1)'(rd_ff.x)) &&
                      ({1'b0, y_ff} < ent_y_end) &&
                      (y_end > (CAND_Y_W + 1)'(rd_ff.y));
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // Skip past the blocker: round the distance to its right edge up to a unit.
   assign gap  = edge_ff - x_ff[CAND_Y_W-1:0];
   assign step = (CAND_X_W'(gap) + UNIT_STEP - CAND_X_W'(1)) &
                 ~(UNIT_STEP - CAND_X_W'(1));

   // Item capture, candidate position and table walk.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tuser;
         w_ff      <= req_tdata[COORD_W-1:0];
         h_ff      <= req_tdata[2*COORD_W-1:COORD_W];
         x_ff      <= '0;
         y_ff      <= '0;
      end else if (cmd.advance) begin
         x_ff <= x_ff + step;
      end else if (cmd.wrap && (x_end > (CAND_X_W + 1)'(board_w_ff))) begin
         x_ff <= '0;
         y_ff <= y_ff + CAND_Y_W'(UNIT_STEP);
      end
      if (cmd.k_reset) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + CNT_W'(1);
      end
      if (cmd.hit) begin
         edge_ff <= ent_x_end[CAND_Y_W-1:0];
      end
   end

   // Rectangle table: written on placement, read at the walk index.
   assign placed = cmd.emit && (cmd.code == ST_PLACED);

   always_ff @(posedge clock) begin
      if (placed) begin
         mem[count_ff[IDX_W-1:0]] <= '{x: x_ff[COORD_W-1:0], y: y_ff[COORD_W-1:0],
                                       w: w_ff, h: h_ff};
      end
      rd_ff <= mem[k_ff[IDX_W-1:0]];
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.emit && (cmd.code == ST_CLEARED)) begin
         count_ff <= '0;
      end else if (placed) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   assign count_ext = {{SLOT_W{1'b0}}, count_ff};

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.code;
         rsp_x_ff      <= placed ? x_ff[COORD_W-1:0] : '0;
         rsp_y_ff      <= placed ? y_ff[COORD_W-1:0] : '0;
         rsp_slot_ff   <= placed ? count_ext[SLOT_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*COORD_W - SLOT_W){1'b0}},
                        rsp_slot_ff, rsp_y_ff, rsp_x_ff};

endmodule

FILE: rtl/rgp_checker.sv
// ----------------------------------------------------------------------------
// rgp_checker
// Port-level checks of the placer, bound to the top level.
// ----------------------------------------------------------------------------
module rgp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rgp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import rgp_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // Only a placed result carries a position and slot.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_PLACED) |-> rsp_tdata == '0)
      else $error("non-placed result with nonzero payload");

   // One item at a time: an accepted item closes the request side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in flight");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind rectangle_grid_placer_core rgp_checker u_rgp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
